>>> hw/rtl/n2a_pkg.sv
package n2a_pkg;

  localparam int unsigned MaxResults = 18;
  localparam int unsigned CntW       = $clog2(MaxResults);

  localparam logic [1:0] KIND_DEC  = 2'd0;
  localparam logic [1:0] KIND_PTR  = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_MINUS,
    S_PRE0,
    S_PREX,
    S_DIGITS
  } state_e;

endpackage

>>> hw/rtl/number_to_ascii_formatter.sv
// Decimal: bit-serial binary-to-BCD conversion, then leading zeros are skipped and each
// character (sign plus digits, at most 18) is sent out. Pointer: a "0x" prefix, then the
// hex nibbles (16), with leading zeros skipped. Character: the single byte, marked last.
// One item at a time: start is taken only while busy is low; results leave one per valid
// cycle and cannot be stalled. Reset (rst_ni low, asynchronous) returns to idle, no output.
module number_to_ascii_formatter #(
  parameter int unsigned INT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [63:0] value_i,
  output logic        valid_o,
  output logic [7:0]  char_code_o,
  output logic        last_o
);
  import n2a_pkg::*;

  localparam int unsigned NDIG    = (INT_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W   = NDIG * 4;
  localparam int unsigned SH_W    = (BCD_W > 64) ? BCD_W : 64;
  localparam int unsigned BCD_PAD = SH_W - BCD_W;
  localparam int unsigned HEX_PAD = SH_W - 64;
  localparam int unsigned MAXD    = (NDIG > 16) ? NDIG : 16;
  localparam int unsigned RW      = $clog2(MAXD + 1);

  state_e            state_q, state_d;
  logic [SH_W-1:0]   sh_q, sh_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              seen_q, seen_d, neg_q, neg_d, hex_q, hex_d;
  logic              valid_q, valid_d, last_q, last_d;
  logic [7:0]        char_q, char_d;

  logic              bcd_load;
  logic              bcd_done;
  logic [BCD_W-1:0]  bcd;
  logic [INT_BITS-1:0] low_v, mag;
  logic              accept;
  logic [3:0]        nib;
  logic [7:0]        nib_char;

  assign accept   = start && !busy;
  assign low_v    = value_i[INT_BITS-1:0];
  assign mag      = low_v[INT_BITS-1] ? (~low_v + 1'b1) : low_v;
  assign bcd_load = accept && (kind_i == KIND_DEC);

  n2a_bcd #(
    .IN_W (INT_BITS),
    .NDIG (NDIG)
  ) u_bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (bcd_load),
    .mag_i  (mag),
    .done_o (bcd_done),
    .bcd_o  (bcd)
  );

  assign nib      = sh_q[SH_W-1 -: 4];
  assign nib_char = (hex_q && nib >= 4'd10) ? CH_A + 8'(nib - 4'd10) : CH_ZERO + 8'(nib);

  always_comb begin
    state_d = state_q;
    sh_d    = sh_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    seen_d  = seen_q;
    neg_d   = neg_q;
    hex_d   = hex_q;
    valid_d = 1'b0;
    last_d  = 1'b0;
    char_d  = char_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          seen_d = 1'b0;
          cnt_d  = '0;
          unique case (kind_i)
            KIND_DEC: begin
              neg_d   = low_v[INT_BITS-1];
              hex_d   = 1'b0;
              state_d = S_CONV;
            end
            KIND_PTR: begin
              hex_d   = 1'b1;
              sh_d    = SH_W'(value_i) << HEX_PAD;
              rem_d   = RW'(16);
              state_d = S_PRE0;
            end
            KIND_CHAR: begin
              valid_d = 1'b1;
              last_d  = 1'b1;
              char_d  = value_i[7:0];
            end
            default: begin
              // unused kind: drop the item
            end
          endcase
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          sh_d    = SH_W'(bcd) << BCD_PAD;
          rem_d   = RW'(NDIG);
          state_d = neg_q ? S_MINUS : S_DIGITS;
        end
      end
      S_MINUS: begin
        valid_d = 1'b1;
        char_d  = CH_MINUS;
        cnt_d   = CntW'(1);
        state_d = S_DIGITS;
      end
      S_PRE0: begin
        valid_d = 1'b1;
        char_d  = CH_ZERO;
        state_d = S_PREX;
      end
      S_PREX: begin
        valid_d = 1'b1;
        char_d  = CH_X;
        cnt_d   = CntW'(2);
        state_d = S_DIGITS;
      end
      S_DIGITS: begin
        sh_d  = {sh_q[SH_W-5:0], 4'd0};
        rem_d = rem_q - 1'b1;
        // skip leading zeros, but always keep the final digit
        if (nib != 4'd0 || seen_q || rem_q == RW'(1)) begin
          valid_d = 1'b1;
          char_d  = nib_char;
          seen_d  = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          last_d  = (rem_q == RW'(1)) || (cnt_q == CntW'(MaxResults - 1));
          if (last_d) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      rem_q   <= '0;
      cnt_q   <= '0;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    neg_q  <= neg_d;
    hex_q  <= hex_d;
    last_q <= last_d;
    char_q <= char_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;
endmodule

>>> hw/rtl/n2a_bcd.sv
module n2a_bcd #(
  parameter int unsigned IN_W = 32,
  parameter int unsigned NDIG = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [IN_W-1:0]   mag_i,
  output logic              done_o,
  output logic [NDIG*4-1:0] bcd_o
);
  localparam int unsigned CW = $clog2(IN_W + 1);

  logic [IN_W-1:0]   bin_q, bin_d;
  logic [NDIG*4-1:0] bcd_q, bcd_d, adj;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              run_q, run_d, done_q, done_d;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (load_i) begin
      bin_d = mag_i;
      bcd_d = '0;
      cnt_d = CW'(IN_W);
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[NDIG*4-2:0], bin_q[IN_W-1]};
      bin_d = {bin_q[IN_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;
endmodule
